@@ src/ddl_pkg.sv @@
// ============================================================================
// ddl_pkg
// Shared types and constants for the deadline first-fit unit assigner.
// ============================================================================
package ddl_pkg;

    // field widths
    localparam int SLOT_W   = 16;
    localparam int FX_W     = 24;
    localparam int PEN_W    = 16;
    localparam int SCORE_W  = 32;
    localparam int IDX_W    = 3;
    localparam int UNITS_W  = 4;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // defaults for the top-level parameters
    localparam int MAX_UNITS_DEF = 8;
    localparam int FRAC_BITS_DEF = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_UNITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZON   = 1'd1;

    // input item
    typedef struct packed {
        logic              first_of_batch;
        logic [SLOT_W-1:0] arrival_slot;
        logic [FX_W-1:0]   duration_fx;
        logic [FX_W-1:0]   deadline_fx;
        logic [PEN_W-1:0]  penalty_value;
    } in_item_t;

    // result item
    typedef struct packed {
        logic               admitted;
        logic [IDX_W-1:0]   unit_index;
        logic [SLOT_W-1:0]  finish_slot;
        logic [SCORE_W-1:0] total_score;
    } out_item_t;

    // packet terms broadcast to every cell
    typedef struct packed {
        logic [SLOT_W-1:0] arrival_slot;
        logic [FX_W-1:0]   duration_fx;
        logic [FX_W-1:0]   deadline_fx;
        logic [SLOT_W-1:0] horizon_slots;
    } probe_t;

    // shared control for the cell chain
    typedef struct packed {
        logic clear;    // zero the unit end
        logic seed_en;  // load the token from the seed input
        logic advance;  // hand the token to the next cell
        logic drop;     // remove the token
        logic write;    // token holder records its ceiling on a fit
    } cell_ctrl_t;

endpackage

@@ src/ddl_cell.sv @@
// ============================================================================
// ddl_cell
// One resource unit: holds its busy-until slot and, while it holds the
// search token, checks whether the current packet fits on it.
// ============================================================================
module ddl_cell #(
    parameter int FRAC_BITS = ddl_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ddl_pkg::cell_ctrl_t         ctrl,
    input  ddl_pkg::probe_t             probe,
    input  logic                        in_use,
    input  logic                        seed,
    input  logic                        prev_tok,
    output logic                        tok,
    output logic                        fit,
    output logic [ddl_pkg::SLOT_W-1:0]  ceil_slot
);
    import ddl_pkg::*;

    localparam int FW  = ((SLOT_W + FRAC_BITS) > FX_W ? (SLOT_W + FRAC_BITS) : FX_W) + 1;
    localparam int CEW = FW + 1;
    localparam logic [CEW-1:0] ONE_M1 = CEW'((64'd1 << FRAC_BITS) - 64'd1);

    logic [SLOT_W-1:0] end_slot_reg, end_slot_next;
    logic              tok_reg, tok_next;
    logic [SLOT_W-1:0] base;
    logic [FW-1:0]     fit_fx;
    logic [CEW-1:0]    ceil_w;
    logic              fits;

    // fit time and its ceiling against this unit's end
    always_comb
    begin
        base   = (probe.arrival_slot > end_slot_reg) ? probe.arrival_slot : end_slot_reg;
        fit_fx = (FW'(base) << FRAC_BITS) + FW'(probe.duration_fx);
        ceil_w = (CEW'(fit_fx) + ONE_M1) >> FRAC_BITS;
        fits   = tok_reg && (fit_fx <= FW'(probe.deadline_fx))
                 && (ceil_w < CEW'(probe.horizon_slots));
    end

    // token hand-off and end update
    always_comb
    begin
        tok_next = tok_reg;
        if (ctrl.drop)
            tok_next = 1'b0;
        else if (ctrl.seed_en)
            tok_next = seed;
        else if (ctrl.advance)
            tok_next = prev_tok & in_use;

        end_slot_next = end_slot_reg;
        if (ctrl.clear)
            end_slot_next = '0;
        else if (ctrl.write && fits)
            end_slot_next = ceil_w[SLOT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg      <= 1'b0;
            end_slot_reg <= '0;
        end
        else
        begin
            tok_reg      <= tok_next;
            end_slot_reg <= end_slot_next;
        end
    end

    assign tok       = tok_reg;
    assign fit       = fits;
    assign ceil_slot = fits ? ceil_w[SLOT_W-1:0] : '0;

endmodule

@@ src/deadline_ru_first_fit_assigner.sv @@
// ============================================================================
// deadline_ru_first_fit_assigner
// Round-robin first-fit deadline admission over a chain of resource units.
// ============================================================================
// One packet is handled at a time. After acceptance the start unit is
// reduced below the unit count (one subtraction per cycle, only needed when
// the count shrank since the last packet), then a search token walks the
// chain of unit cells, one unit per cycle, from the start unit round the
// ring, until a unit fits or every unit in use has been tried. The result
// is held in a result register and moved into the output register once that
// is free. The next packet is taken as soon as the result sits in the output
// register, even if it has not yet been collected.
module deadline_ru_first_fit_assigner #(
    parameter int MAX_UNITS = ddl_pkg::MAX_UNITS_DEF,
    parameter int FRAC_BITS = ddl_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ddl_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output ddl_pkg::out_item_t             out_data,
    input  logic                           cfg_write,
    input  logic [ddl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ddl_pkg::CFG_W-1:0]      cfg_data
);
    import ddl_pkg::*;

    localparam int UW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int CW = $clog2(MAX_UNITS + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_WRAP   = 4'b0010,
        S_SEARCH = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [UNITS_W-1:0]  num_units_reg;
    logic [SLOT_W-1:0]   horizon_reg;
    in_item_t            pkt_reg, pkt_next;
    logic [UW-1:0]       ptr_reg, ptr_next;
    logic [UW-1:0]       start_reg, start_next;
    logic [UW-1:0]       cur_reg, cur_next;
    logic [CW-1:0]       ctr_reg, ctr_next;
    logic [SCORE_W-1:0]  score_reg, score_next;
    out_item_t           res_reg, res_next;
    out_item_t           out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [CW-1:0]        m_count;
    logic [UW-1:0]        last_idx;
    logic                 last_step;
    logic                 accept;
    logic                 any_fit;
    logic [SLOT_W-1:0]    found_ceil;
    logic [SCORE_W:0]     score_sum;
    logic [SCORE_W-1:0]   score_sat;
    cell_ctrl_t           ctrl;
    probe_t               probe;
    logic [MAX_UNITS-1:0] tok_vec, fit_vec, seed_vec, prev_vec, use_vec;
    logic [SLOT_W-1:0]    ceil_arr [MAX_UNITS];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_units_reg <= UNITS_W'(1);
            horizon_reg   <= '1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_NUM_UNITS: num_units_reg <= cfg_data[UNITS_W-1:0];
                REG_HORIZON:   horizon_reg   <= cfg_data[SLOT_W-1:0];
                default:       ;
            endcase
        end
    end

    // units in use, clamped to one..MAX_UNITS
    always_comb
    begin
        if (num_units_reg == '0)
            m_count = CW'(1);
        else if (32'(num_units_reg) > MAX_UNITS)
            m_count = CW'(MAX_UNITS);
        else
            m_count = CW'(num_units_reg);
        last_idx  = UW'(m_count - CW'(1));
        last_step = (ctr_reg == CW'(m_count - CW'(1)));
    end

    // cell chain
    assign probe.arrival_slot  = pkt_reg.arrival_slot;
    assign probe.duration_fx   = pkt_reg.duration_fx;
    assign probe.deadline_fx   = pkt_reg.deadline_fx;
    assign probe.horizon_slots = horizon_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_UNITS; gi++)
        begin : g_cell
            assign seed_vec[gi] = (start_reg == UW'(gi));
            assign use_vec[gi]  = (32'(gi) < 32'(m_count));
            if (gi == 0)
            begin : g_head
                assign prev_vec[gi] = tok_vec[last_idx];
            end
            else
            begin : g_link
                assign prev_vec[gi] = tok_vec[gi-1];
            end
            ddl_cell #(
                .FRAC_BITS (FRAC_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .probe     (probe),
                .in_use    (use_vec[gi]),
                .seed      (seed_vec[gi]),
                .prev_tok  (prev_vec[gi]),
                .tok       (tok_vec[gi]),
                .fit       (fit_vec[gi]),
                .ceil_slot (ceil_arr[gi])
            );
        end
    endgenerate

    // only the token holder can report a fit, so an or gathers its ceiling
    always_comb
    begin
        found_ceil = '0;
        for (int i = 0; i < MAX_UNITS; i++)
            found_ceil = found_ceil | ceil_arr[i];
        any_fit = |fit_vec;
    end

    // saturating score update
    always_comb
    begin
        score_sum = {1'b0, score_reg} + (SCORE_W + 1)'(pkt_reg.penalty_value);
        score_sat = score_sum[SCORE_W] ? '1 : score_sum[SCORE_W-1:0];
    end

    assign accept   = (state_reg == S_IDLE) && in_valid;
    assign in_ready = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pkt_next       = pkt_reg;
        ptr_next       = ptr_reg;
        start_next     = start_reg;
        cur_next       = cur_reg;
        ctr_next       = ctr_reg;
        score_next     = score_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pkt_next   = in_data;
                    ctrl.clear = in_data.first_of_batch;
                    if (in_data.first_of_batch)
                    begin
                        ptr_next   = '0;
                        score_next = '0;
                        start_next = '0;
                    end
                    else
                        start_next = ptr_reg;
                    state_next = S_WRAP;
                end
            end
            S_WRAP:
            begin
                if (32'(start_reg) >= 32'(m_count))
                    start_next = start_reg - UW'(m_count);
                else
                begin
                    ctrl.seed_en = 1'b1;
                    cur_next     = start_reg;
                    ctr_next     = '0;
                    state_next   = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                ctrl.write = 1'b1;
                if (any_fit)
                begin
                    ctrl.drop            = 1'b1;
                    ptr_next             = (cur_reg == last_idx) ? '0 : cur_reg + UW'(1);
                    score_next           = score_sat;
                    res_next.admitted    = 1'b1;
                    res_next.unit_index  = IDX_W'(cur_reg);
                    res_next.finish_slot = found_ceil;
                    res_next.total_score = score_sat;
                    state_next           = S_DONE;
                end
                else if (last_step)
                begin
                    ctrl.drop            = 1'b1;
                    res_next.admitted    = 1'b0;
                    res_next.unit_index  = '0;
                    res_next.finish_slot = '0;
                    res_next.total_score = score_reg;
                    state_next           = S_DONE;
                end
                else
                begin
                    ctrl.advance = 1'b1;
                    cur_next     = (cur_reg == last_idx) ? '0 : cur_reg + UW'(1);
                    ctr_next     = ctr_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            score_reg     <= '0;
            out_valid_reg <= 1'b0;
            start_reg     <= '0;
            cur_reg       <= '0;
            ctr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            score_reg     <= score_next;
            out_valid_reg <= out_valid_next;
            start_reg     <= start_next;
            cur_reg       <= cur_next;
            ctr_reg       <= ctr_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pkt_reg <= pkt_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // exactly one cell holds the token while searching
    a_token_onehot : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> $onehot(tok_vec))
        else $error("search token lost or duplicated");

    // token never sits in the chain outside a search
    a_token_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SEARCH) |-> (tok_vec == '0))
        else $error("stray search token");

    // the token position tracked by the sequencer matches the chain
    a_token_pos : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> tok_vec[cur_reg])
        else $error("token position mismatch");

    // an admitted packet always finishes below the horizon
    a_finish_horizon : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.admitted) |-> (out_reg.finish_slot < horizon_reg))
        else $error("finish slot not below horizon");

endmodule
